[rtl/core/qat_pkg.sv]
// ----------------------------------------------------------------------------
// qat_pkg
// Shared constants and types for the quoted argument tokenizer.
// ----------------------------------------------------------------------------
package qat_pkg;

  // Character codes that the lexer reacts to.
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Default depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;

  // One command from the front: a data byte, a backslash followed by a
  // data byte, or a token-end mark.
  typedef struct packed {
    logic       two;     // emit a backslash before the byte
    logic       is_end;  // token-end mark instead of a byte
    logic [7:0] data;
  } cmd_t;

endpackage

[rtl/core/qat_front.sv]
// ----------------------------------------------------------------------------
// qat_front
// Lexer front end: holds the mode state and turns each accepted item into
// at most one command for the back end.
// ----------------------------------------------------------------------------
module qat_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     char_code,
  input  logic           end_of_text,
  output logic           push,
  output qat_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_DQUOTE = 3'd1,
    MODE_SQUOTE = 3'd2,
    MODE_ESCAPE = 3'd3,
    MODE_BTICK  = 3'd4
  } mode_t;

  mode_t      lex_mode;
  mode_t      lex_mode_next;
  mode_t      saved_mode;
  mode_t      saved_mode_next;
  logic       token_open;
  logic       token_open_next;
  logic [7:0] closer;

  // Next-state and command decode for one item.
  always_comb begin
    lex_mode_next   = lex_mode;
    saved_mode_next = saved_mode;
    token_open_next = token_open;
    push            = 1'b0;
    cmd.two         = 1'b0;
    cmd.is_end      = 1'b0;
    cmd.data        = char_code;
    closer          = qat_pkg::CH_SQUOTE;

    if (end_of_text) begin
      // Flush an open token and return to the reset state.
      push            = token_open;
      cmd.is_end      = 1'b1;
      cmd.data        = 8'd0;
      lex_mode_next   = MODE_NORMAL;
      saved_mode_next = MODE_NORMAL;
      token_open_next = 1'b0;
    end else begin
      case (lex_mode)
        MODE_ESCAPE: begin
          if (saved_mode == MODE_DQUOTE) begin
            closer = qat_pkg::CH_DQUOTE;
          end else if (saved_mode == MODE_BTICK) begin
            closer = qat_pkg::CH_BTICK;
          end else begin
            closer = qat_pkg::CH_SQUOTE;
          end
          push            = 1'b1;
          cmd.two         = (char_code != closer);
          token_open_next = 1'b1;
          lex_mode_next   = saved_mode;
          saved_mode_next = MODE_NORMAL;
        end
        MODE_DQUOTE, MODE_SQUOTE, MODE_BTICK: begin
          if (lex_mode == MODE_DQUOTE) begin
            closer = qat_pkg::CH_DQUOTE;
          end else if (lex_mode == MODE_SQUOTE) begin
            closer = qat_pkg::CH_SQUOTE;
          end else begin
            closer = qat_pkg::CH_BTICK;
          end
          if (char_code == qat_pkg::CH_BSLASH) begin
            saved_mode_next = lex_mode;
            lex_mode_next   = MODE_ESCAPE;
          end else begin
            push            = 1'b1;
            token_open_next = 1'b1;
            if (char_code == closer) begin
              lex_mode_next   = saved_mode;
              saved_mode_next = MODE_NORMAL;
            end
          end
        end
        default: begin
          // Normal mode; unused codes behave the same way.
          if (char_code == qat_pkg::CH_SPACE || char_code == qat_pkg::CH_TAB) begin
            if (token_open) begin
              push            = 1'b1;
              cmd.is_end      = 1'b1;
              cmd.data        = 8'd0;
              token_open_next = 1'b0;
            end
          end else begin
            if (char_code == qat_pkg::CH_SQUOTE) begin
              saved_mode_next = lex_mode;
              lex_mode_next   = MODE_SQUOTE;
            end else if (char_code == qat_pkg::CH_DQUOTE) begin
              saved_mode_next = lex_mode;
              lex_mode_next   = MODE_DQUOTE;
            end else if (char_code == qat_pkg::CH_BTICK) begin
              saved_mode_next = lex_mode;
              lex_mode_next   = MODE_BTICK;
            end
            push            = 1'b1;
            token_open_next = 1'b1;
          end
        end
      endcase
    end
  end

  // Lexer state advances on each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode   <= MODE_NORMAL;
      saved_mode <= MODE_NORMAL;
      token_open <= 1'b0;
    end else if (accept) begin
      lex_mode   <= lex_mode_next;
      saved_mode <= saved_mode_next;
      token_open <= token_open_next;
    end
  end

endmodule

[rtl/core/qat_queue.sv]
// ----------------------------------------------------------------------------
// qat_queue
// Small command queue that decouples the lexer front from the output back.
// ----------------------------------------------------------------------------
module qat_queue #(
  parameter int unsigned DEPTH = qat_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  qat_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output qat_pkg::cmd_t  head,
  output logic           empty,
  output logic           full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  qat_pkg::cmd_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_FULL);
  assign head  = slots[rd_ptr];

  // Storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/qat_back.sv]
// ----------------------------------------------------------------------------
// qat_back
// Output back end: expands queued commands into results and holds them in
// the output register until the transfer completes.
// ----------------------------------------------------------------------------
module qat_back (
  input  logic           clk,
  input  logic           rst,
  input  qat_pkg::cmd_t  head,
  input  logic           empty,
  output logic           pop,
  output logic           result_valid,
  input  logic           result_stall,
  output logic [7:0]     out_byte,
  output logic           token_end,
  output logic           run_last
);

  logic advance;
  logic phase;  // backslash of a two-result command already sent

  assign advance = !result_valid || !result_stall;
  assign pop     = advance && !empty && (!head.two || phase);

  // Control: output valid and expansion phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      phase        <= 1'b0;
    end else if (advance) begin
      result_valid <= !empty;
      if (!empty) begin
        phase <= head.two && !phase;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (advance && !empty) begin
      if (head.two && !phase) begin
        out_byte  <= qat_pkg::CH_BSLASH;
        token_end <= 1'b0;
        run_last  <= 1'b0;
      end else begin
        out_byte  <= head.data;
        token_end <= head.is_end;
        run_last  <= 1'b1;
      end
    end
  end

endmodule

[rtl/core/quoted_argument_tokenizer.sv]
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer
// Splits a byte stream into shell-style command-line arguments.
// ----------------------------------------------------------------------------
// The front lexer takes one item per cycle and pushes at most one command into
// a small queue; the back end delivers one result per cycle from its output
// register while result_stall is low. A plain byte or a token end gives one
// result, an escaped byte other than the matching quote gives two (backslash,
// then the byte), and blanks outside a token, backslashes inside quotes and an
// end marker with no open token give none. Output throughput is set by the
// single output register. The first result of an item passes through a queue
// slot and then the output register. Item stall rises only when the command
// queue is full.
module quoted_argument_tokenizer #(
  parameter int unsigned QUEUE_DEPTH = qat_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [7:0] char_code,
  input  logic       end_of_text,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic       token_end,
  output logic       run_last
);

  logic          accept;
  logic          front_push;
  qat_pkg::cmd_t front_cmd;
  logic          q_push;
  logic          q_pop;
  logic          q_empty;
  logic          q_full;
  qat_pkg::cmd_t q_head;

  // Item transfer.
  assign item_stall = q_full;
  assign accept     = item_valid && !item_stall;
  assign q_push     = accept && front_push;

  qat_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .push        (front_push),
    .cmd         (front_cmd)
  );

  qat_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  qat_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .empty        (q_empty),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .token_end    (token_end),
    .run_last     (run_last)
  );

endmodule
